// ----- src/hchc_pkg.sv -----
`default_nettype none

package hchc_pkg;

   // number of hotness thresholds, element 0 is the highest (level 6)
   localparam int LEVELS = 6;
   localparam int TENTHS_W = 8;

   // request queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_PTR_W = 2;

   // response payload: hit_count, hot_level, in_selection, padded to bytes
   localparam int RSP_DATA_W = 40;

   // module filter value that passes every module
   localparam logic [4:0] FILTER_ALL = 5'h1f;

   typedef enum logic {
      KIND_HIT   = 1'b0,
      KIND_QUERY = 1'b1
   } hchc_kind_type;

   typedef logic [LEVELS-1:0][TENTHS_W-1:0] hchc_tenths_type;

   // level6 in the lowest element, level1 in the highest
   localparam hchc_tenths_type TENTHS_RESET = {8'd13, 8'd14, 8'd15, 8'd20, 8'd25, 8'd30};

   typedef struct packed {
      hchc_kind_type kind;
      logic          in_range;
      logic          in_selection;
      logic [3:0]    module_index;
      logic [4:0]    chip_index;
      logic [6:0]    channel_index;
   } hchc_item_type;

endpackage

`default_nettype wire

// ----- src/hchc_front.sv -----
`default_nettype none

module hchc_front #(
   parameter int MODULES  = 14,
   parameter int CHIPS    = 27,
   parameter int CHANNELS = 128
) (
   input  logic                    req_tvalid,
   output logic                    req_tready,
   input  logic                    req_tuser,   // req_type
   input  logic [15:0]             req_tdata,   // module_index, chip_index, channel_index
   input  logic [4:0]              module_filter,
   input  logic                    queue_full,
   input  logic                    clear_busy,
   output logic                    push,
   output hchc_pkg::hchc_item_type push_item
);
   import hchc_pkg::*;

   logic [3:0] module_idx;
   logic [4:0] chip_idx;
   logic [6:0] channel_idx;
   logic       in_range;
   logic       selected;

   assign module_idx  = req_tdata[3:0];
   assign chip_idx    = req_tdata[8:4];
   assign channel_idx = req_tdata[15:9];

   assign in_range = (32'(module_idx) < MODULES) && (32'(chip_idx) < CHIPS)
                     && (32'(channel_idx) < CHANNELS);

   // a filter naming no module simply never matches
   assign selected = in_range && ((module_filter == FILTER_ALL)
                     || (module_filter == {1'b0, module_idx}));

   assign req_tready = !queue_full && !clear_busy;

   always_comb begin
      push_item.kind          = hchc_kind_type'(req_tuser);
      push_item.in_range      = in_range;
      push_item.in_selection  = selected;
      push_item.module_index  = module_idx;
      push_item.chip_index    = chip_idx;
      push_item.channel_index = channel_idx;
   end

   // hits outside the histogram are dropped here
   assign push = req_tvalid && req_tready && (req_tuser == KIND_QUERY || in_range);

endmodule

`default_nettype wire

// ----- src/hchc_fifo.sv -----
`default_nettype none

module hchc_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  hchc_pkg::hchc_item_type push_item,
   input  logic                    pop,
   output hchc_pkg::hchc_item_type head,
   output logic                    empty,
   output logic                    full
);
   import hchc_pkg::*;

   hchc_item_type          entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]   count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign head  = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

`default_nettype wire

// ----- src/hchc_back.sv -----
`default_nettype none

module hchc_back #(
   parameter int MODULES     = 14,
   parameter int CHIPS       = 27,
   parameter int CHANNELS    = 128,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   input  hchc_pkg::hchc_item_type           head,
   input  logic                              queue_empty,
   output logic                              pop,
   input  hchc_pkg::hchc_tenths_type         level_tenths,
   output logic                              clear_busy,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [hchc_pkg::RSP_DATA_W-1:0]   rsp_tdata
);
   import hchc_pkg::*;

   localparam int DEPTH = MODULES * CHIPS * CHANNELS;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW    = COUNT_WIDTH;
   localparam int PW    = CW + 16;
   localparam int CMPW  = (CW + 20 > 48) ? CW + 20 : 48;
   localparam int CEXT  = CW + 32;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_UPDATE,
      ST_FETCH,
      ST_SCALE,
      ST_DONE
   } state_type;

   state_type                 state_ff, state_in;
   logic [AW-1:0]             clear_ff, clear_in;
   hchc_item_type             item_ff, item_in;
   logic [AW-1:0]             addr_ff, addr_in;
   logic [CW-1:0]             count_ff, count_in;
   logic [PW-1:0]             a_ff, a_in;
   logic [47:0]               prod_ff, prod_in;
   logic [2:0]                k_ff, k_in;
   logic [2:0]                level_ff, level_in;
   logic [39:0]               total_ff, total_in;
   logic [15:0]               nonzero_ff, nonzero_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_DATA_W-1:0]     rsp_data_ff, rsp_data_in;

   logic [CW-1:0]             mem [DEPTH];
   logic [CW-1:0]             rd_ff;
   logic                      we;
   logic [AW-1:0]             waddr;
   logic [CW-1:0]             wdata;
   logic [AW-1:0]             head_addr;
   logic [CW-1:0]             count_inc;
   logic [CMPW-1:0]           a10;
   logic [CEXT-1:0]           count_ext;
   logic [31:0]               hit32;

   assign head_addr = AW'((32'(head.module_index) * CHIPS + 32'(head.chip_index)) * CHANNELS
                          + 32'(head.channel_index));

   assign count_inc = (rd_ff == '1) ? rd_ff : rd_ff + 1'b1;

   // count * nonzero * 10 as shift and add
   assign a10 = (CMPW'(a_ff) << 3) + (CMPW'(a_ff) << 1);

   assign count_ext = CEXT'(count_ff);
   assign hit32     = (count_ext[CEXT-1:32] != '0) ? 32'hffff_ffff : count_ext[31:0];

   assign clear_busy = (state_ff == ST_CLEAR);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rd_ff <= mem[head_addr];
   end

   always_comb begin
      state_in     = state_ff;
      clear_in     = clear_ff;
      item_in      = item_ff;
      addr_in      = addr_ff;
      count_in     = count_ff;
      a_in         = a_ff;
      prod_in      = prod_ff;
      k_in         = k_ff;
      level_in     = level_ff;
      total_in     = total_ff;
      nonzero_in   = nonzero_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      pop          = 1'b0;
      we           = 1'b0;
      waddr        = addr_ff;
      wdata        = count_inc;

      case (state_ff)
         ST_CLEAR: begin
            we       = 1'b1;
            waddr    = clear_ff;
            wdata    = '0;
            clear_in = clear_ff + 1'b1;
            if (clear_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!queue_empty) begin
               pop     = 1'b1;
               item_in = head;
               addr_in = head_addr;
               if (!head.in_range) begin
                  count_in = '0;
                  level_in = '0;
                  state_in = ST_DONE;
               end else if (head.kind == KIND_HIT) begin
                  state_in = ST_UPDATE;
               end else begin
                  state_in = ST_FETCH;
               end
            end
         end
         ST_UPDATE: begin
            // bin read landed in rd_ff, write back the saturated increment
            we = 1'b1;
            if (rd_ff == '0 && nonzero_ff != '1) begin
               nonzero_in = nonzero_ff + 1'b1;
            end
            if (total_ff != '1) begin
               total_in = total_ff + 1'b1;
            end
            state_in = ST_IDLE;
         end
         ST_FETCH: begin
            count_in = rd_ff;
            if (nonzero_ff == '0) begin
               level_in = '0;
               state_in = ST_DONE;
            end else begin
               a_in     = PW'(rd_ff) * PW'(nonzero_ff);
               k_in     = '0;
               state_in = ST_SCALE;
            end
         end
         ST_SCALE: begin
            // product for threshold k is formed here, compared in the next cycle
            if (32'(k_ff) < LEVELS) begin
               prod_in = 48'(level_tenths[k_ff]) * 48'(total_ff);
            end
            k_in = k_ff + 1'b1;
            if (k_ff != '0 && a10 > CMPW'(prod_ff)) begin
               level_in = 3'(LEVELS + 1) - k_ff;
               state_in = ST_DONE;
            end else if (k_ff == 3'(LEVELS)) begin
               level_in = '0;
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_DATA_W-36){1'b0}}, item_ff.in_selection, level_ff, hit32};
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clear_ff     <= '0;
         k_ff         <= '0;
         total_ff     <= '0;
         nonzero_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clear_ff     <= clear_in;
         k_ff         <= k_in;
         total_ff     <= total_in;
         nonzero_ff   <= nonzero_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      addr_ff     <= addr_in;
      count_ff    <= count_in;
      a_ff        <= a_in;
      prod_ff     <= prod_in;
      level_ff    <= level_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // every new nonzero bin comes with a counted hit
   a_nonzero_le_total: assert property (@(posedge clock) disable iff (reset)
      40'(nonzero_ff) <= total_ff)
      else $error("nonzero bin count exceeds total hits");

   a_queue_empty_in_clear: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_CLEAR |-> queue_empty)
      else $error("request queued during clearing pass");

   a_hot_needs_bins: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff[34:32] != 3'd0 |-> nonzero_ff != '0)
      else $error("hot level reported with no nonzero bin");

   a_rsp_from_done: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == ST_DONE)
      else $error("response raised outside done state");
`endif

endmodule

`default_nettype wire

// ----- src/hot_channel_histogram_classifier_unit.sv -----
`default_nettype none

// hit-occupancy histogram with hot-channel classification. a request with
// req_tuser 0 is a hit that adds one to the saturating bin of its module,
// chip and channel (hits outside the histogram are dropped); a request with
// req_tuser 1 is a query that returns one response with the bin count, a
// hotness level 0..6 and whether the module passes the module filter. the
// level is the highest level whose threshold t (in tenths of the mean) has
// count * nonzero_bins * 10 > t * total_hits, tested level 6 first.
// after reset the bin memory is cleared one entry per cycle, over all
// MODULES*CHIPS*CHANNELS entries (48384 with the defaults); req_tready stays
// low during the clearing pass, csr writes are taken throughout. requests pass a
// four-entry queue; the back end then handles a hit as a memory read, then
// a write back, and a query that falls outside the histogram goes straight
// to the response, one with no nonzero bin after the read, any other as read,
// count*nonzero product, then one threshold product per cycle over a shared
// multiplier, plus waiting for the response register to drain
module hot_channel_histogram_classifier_unit #(
   parameter int MODULES     = 14,
   parameter int CHIPS       = 27,
   parameter int CHANNELS    = 128,
   parameter int COUNT_WIDTH = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic                            req_tuser,   // req_type
   input  logic [15:0]                     req_tdata,   // module_index[3:0], chip_index[8:4],
                                                        // channel_index[15:9]
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [hchc_pkg::RSP_DATA_W-1:0] rsp_tdata,   // hit_count[31:0], hot_level[34:32],
                                                        // in_selection[35], zero pad
   // register write channel
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [2:0]                      csr_index,
   input  logic [7:0]                      csr_data
);
   import hchc_pkg::*;

   // register map
   localparam logic [2:0] CSR_MODULE_FILTER = 3'd0;
   localparam logic [2:0] CSR_LEVEL6        = 3'd1;
   localparam logic [2:0] CSR_LEVEL5        = 3'd2;
   localparam logic [2:0] CSR_LEVEL4        = 3'd3;
   localparam logic [2:0] CSR_LEVEL3        = 3'd4;
   localparam logic [2:0] CSR_LEVEL2        = 3'd5;
   localparam logic [2:0] CSR_LEVEL1        = 3'd6;

   logic [4:0]      module_filter_ff;
   hchc_tenths_type level_tenths_ff;

   hchc_item_type   push_item;
   hchc_item_type   head;
   logic            push;
   logic            pop;
   logic            queue_empty;
   logic            queue_full;
   logic            clear_busy;

   // registers accept a write every cycle
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         module_filter_ff <= FILTER_ALL;
         level_tenths_ff  <= TENTHS_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_MODULE_FILTER: begin
               module_filter_ff <= csr_data[4:0];
            end
            CSR_LEVEL6, CSR_LEVEL5, CSR_LEVEL4, CSR_LEVEL3, CSR_LEVEL2, CSR_LEVEL1: begin
               // level6 sits in element 0
               level_tenths_ff[3'(csr_index - CSR_LEVEL6)] <= csr_data;
            end
            default: begin
               // unmapped index, write dropped
            end
         endcase
      end
   end

   // front: decode, range check, filter match
   hchc_front #(
      .MODULES  (MODULES),
      .CHIPS    (CHIPS),
      .CHANNELS (CHANNELS)
   ) u_front (
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .req_tuser     (req_tuser),
      .req_tdata     (req_tdata),
      .module_filter (module_filter_ff),
      .queue_full    (queue_full),
      .clear_busy    (clear_busy),
      .push          (push),
      .push_item     (push_item)
   );

   // decouples request intake from the bin update / classification engine
   hchc_fifo u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head      (head),
      .empty     (queue_empty),
      .full      (queue_full)
   );

   // back: bin memory, running totals, threshold search, response register
   hchc_back #(
      .MODULES     (MODULES),
      .CHIPS       (CHIPS),
      .CHANNELS    (CHANNELS),
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .head         (head),
      .queue_empty  (queue_empty),
      .pop          (pop),
      .level_tenths (level_tenths_ff),
      .clear_busy   (clear_busy),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
`default_nettype none

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import hchc_pkg::*;

   // histogram geometry, matches the block's default parameters
   localparam int N_MOD  = 14;
   localparam int N_CHIP = 27;
   localparam int N_CHAN = 128;

   // register indexes of the write channel
   localparam logic [2:0] REG_FILTER   = 3'd0;
   localparam logic [2:0] REG_LEVEL6   = 3'd1;
   localparam logic [2:0] REG_LEVEL1   = 3'd6;
   localparam logic [2:0] REG_UNMAPPED = 3'd7;

   // quiet cycles tolerated, longer than the clearing pass
   localparam int STALL_LIMIT   = 250000;
   // cycles left for queued hits to land before a register write
   localparam int SETTLE_CYCLES = 32;
   localparam int PHASE_ITEMS   = 322;
   localparam int HOT_BINS      = 8;

   typedef struct packed {
      hchc_kind_type kind;
      logic [3:0]    mod_idx;
      logic [4:0]    chip_idx;
      logic [6:0]    chan_idx;
   } request_type;

   typedef struct packed {
      logic [31:0] hit_count;
      logic [2:0]  hot_level;
      logic        in_selection;
   } bin_report_type;

   typedef struct packed {
      logic [2:0] index;
      logic [7:0] data;
   } reg_write_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic        req_tuser = 1'b0;
   logic [15:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [7:0]  csr_data = '0;

   hot_channel_histogram_classifier_unit u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------
   // shadow histogram: bin counts, totals and the register copies
   // ---------------------------------------------------------------
   logic [31:0] bin_tally [int unsigned];
   logic [39:0] total_hits   = '0;
   logic [15:0] nonzero_bins = '0;
   logic [4:0]  module_filter = FILTER_ALL;
   // element 0 is the level6 threshold, element 5 the level1 one
   logic [7:0]  level_tenths [LEVELS] = '{8'd30, 8'd25, 8'd20, 8'd15, 8'd14, 8'd13};

   request_type    pending_requests [$];
   bin_report_type awaited_reports  [$];
   reg_write_type  pending_writes   [$];

   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned mismatches = 0;
   int unsigned n_hits = 0, n_queries = 0, n_dropped = 0, n_replies = 0, n_writes = 0;
   int unsigned quiet_cycles = 0;
   request_type hot_set [HOT_BINS];

   // highest threshold passed, scanning from level6 down, by cross-multiplication
   function automatic logic [2:0] hotness(input logic [31:0] count);
      longint unsigned prod;
      longint unsigned bound;
      if (nonzero_bins == 0) return 3'd0;
      prod = 64'(count) * 64'(nonzero_bins);
      for (int k = 0; k < LEVELS; k++) begin
         bound = 64'(level_tenths[k]) * 64'(total_hits);
         if (prod > bound / 10) return 3'(LEVELS - k);
      end
      return 3'd0;
   endfunction

   // apply one accepted request to the shadow histogram; a query queues its report
   task automatic histogram_apply(input request_type rq);
      bit             in_range;
      int unsigned    slot;
      logic [31:0]    cnt;
      bin_report_type rep;
      in_range = (rq.mod_idx < N_MOD) && (rq.chip_idx < N_CHIP) && (rq.chan_idx < N_CHAN);
      slot = (int'(rq.mod_idx) * N_CHIP + int'(rq.chip_idx)) * N_CHAN + int'(rq.chan_idx);
      cnt = (in_range && bin_tally.exists(slot)) ? bin_tally[slot] : 32'd0;
      if (rq.kind == KIND_HIT) begin
         if (!in_range) begin
            n_dropped++;
         end else begin
            if (cnt == 32'd0 && nonzero_bins != 16'hffff) nonzero_bins++;
            if (cnt != 32'hffff_ffff) bin_tally[slot] = cnt + 32'd1;
            if (total_hits != 40'hff_ffff_ffff) total_hits++;
         end
         n_hits++;
      end else begin
         rep = '0;
         // out-of-range query reports all zero
         if (in_range) begin
            rep.hit_count    = cnt;
            rep.hot_level    = hotness(cnt);
            rep.in_selection = (module_filter == FILTER_ALL) ||
                               (module_filter == {1'b0, rq.mod_idx});
         end
         awaited_reports.push_back(rep);
         n_queries++;
      end
   endtask

   // ---------------------------------------------------------------
   // request driver: holds tvalid until accepted, idles at random
   // ---------------------------------------------------------------
   always @(posedge clock) begin : req_driver
      request_type rq;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            rq.kind     = hchc_kind_type'(req_tuser);
            rq.mod_idx  = req_tdata[3:0];
            rq.chip_idx = req_tdata[8:4];
            rq.chan_idx = req_tdata[15:9];
            histogram_apply(rq);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_requests.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               rq = pending_requests.pop_front();
               req_tvalid <= 1'b1;
               req_tuser  <= rq.kind;
               req_tdata  <= {rq.chan_idx, rq.chip_idx, rq.mod_idx};
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // register write driver, updates the shadow copy on acceptance
   // ---------------------------------------------------------------
   always @(posedge clock) begin : csr_driver
      reg_write_type wr;
      if (reset) begin
         csr_valid <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == REG_FILTER) module_filter = csr_data[4:0];
            else if (csr_index <= REG_LEVEL1) level_tenths[csr_index - REG_LEVEL6] = csr_data;
            n_writes++;
         end
         if (!csr_valid || csr_ready) begin
            if (pending_writes.size() != 0) begin
               wr = pending_writes.pop_front();
               csr_valid <= 1'b1;
               csr_index <= wr.index;
               csr_data  <= wr.data;
            end else begin
               csr_valid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------
   // response monitor: compares each reply with the oldest report
   // ---------------------------------------------------------------
   always @(posedge clock) begin : rsp_monitor
      bin_report_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            n_replies++;
            if (awaited_reports.size() == 0) begin
               $display("%0t: reply with nothing awaited, data %h", $time, rsp_tdata);
               mismatches++;
            end else begin
               want = awaited_reports.pop_front();
               if (rsp_tdata[31:0] !== want.hit_count) begin
                  $display("%0t: hit_count expected %0d actual %0d",
                           $time, want.hit_count, rsp_tdata[31:0]);
                  mismatches++;
               end
               if (rsp_tdata[34:32] !== want.hot_level) begin
                  $display("%0t: hot_level expected %0d actual %0d",
                           $time, want.hot_level, rsp_tdata[34:32]);
                  mismatches++;
               end
               if (rsp_tdata[35] !== want.in_selection) begin
                  $display("%0t: in_selection expected %0b actual %0b",
                           $time, want.in_selection, rsp_tdata[35]);
                  mismatches++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // watchdog on cycles in which no channel moves anything
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("hot_channel_histogram_classifier_unit regression: fail");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic push_req(input hchc_kind_type kind, input int m, input int c, input int h);
      request_type rq;
      rq.kind     = kind;
      rq.mod_idx  = 4'(m);
      rq.chip_idx = 5'(c);
      rq.chan_idx = 7'(h);
      pending_requests.push_back(rq);
   endtask

   task automatic write_reg(input logic [2:0] index, input logic [7:0] data);
      pending_writes.push_back('{index: index, data: data});
   endtask

   // block idle: all requests taken, all reports back, queued hits landed
   task automatic settle();
      while (pending_requests.size() != 0 || req_tvalid) @(posedge clock);
      while (awaited_reports.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic wait_writes();
      while (pending_writes.size() != 0 || csr_valid) @(posedge clock);
   endtask

   // one random request; returns 0 when the block would simply drop it
   function automatic bit random_request(output request_type rq);
      int unsigned r;
      int unsigned j;
      r = $urandom_range(99);
      rq.kind     = (r < 67) ? KIND_HIT : KIND_QUERY;
      rq.mod_idx  = 4'($urandom_range(N_MOD - 1));
      rq.chip_idx = 5'($urandom_range(N_CHIP - 1));
      rq.chan_idx = 7'($urandom_range(N_CHAN - 1));
      if (r < 45) begin
         // skewed toward the low end of the hot set so counts spread out
         j = $urandom_range(HOT_BINS - 1);
         if ($urandom_range(1)) j = j * $urandom_range(HOT_BINS - 1) / (HOT_BINS - 1);
         rq = hot_set[j];
         rq.kind = KIND_HIT;
      end else if ((r >= 60 && r < 67) || r >= 95) begin
         // unconstrained fields, often outside the histogram
         rq.mod_idx  = 4'($urandom);
         rq.chip_idx = 5'($urandom);
         rq.chan_idx = 7'($urandom);
      end else if (r >= 67 && r < 87) begin
         rq = hot_set[$urandom_range(HOT_BINS - 1)];
         rq.kind = KIND_QUERY;
      end
      return !(rq.kind == KIND_HIT &&
               (rq.mod_idx >= N_MOD || rq.chip_idx >= N_CHIP));
   endfunction

   initial begin : stimulus
      request_type rq;
      int          counted;
      int          t;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed part, reset thresholds and an open filter
      send_idle_pct = 30;
      recv_idle_pct = 59;
      push_req(KIND_QUERY, 0, 0, 0);       // empty store: no nonzero bin
      push_req(KIND_QUERY, 13, 26, 127);
      push_req(KIND_HIT, 0, 0, 0);
      repeat (3) push_req(KIND_HIT, 13, 26, 127);
      push_req(KIND_HIT, 14, 0, 0);        // hits outside the histogram
      push_req(KIND_HIT, 15, 31, 127);
      push_req(KIND_HIT, 0, 27, 0);
      push_req(KIND_HIT, 3, 31, 5);
      push_req(KIND_QUERY, 0, 0, 0);
      push_req(KIND_QUERY, 13, 26, 127);
      push_req(KIND_QUERY, 14, 3, 3);      // queries outside the histogram
      push_req(KIND_QUERY, 15, 31, 127);
      push_req(KIND_QUERY, 2, 27, 0);
      repeat (5) push_req(KIND_HIT, 13, 26, 127);
      push_req(KIND_HIT, 7, 13, 64);
      push_req(KIND_QUERY, 13, 26, 127);
      push_req(KIND_QUERY, 7, 13, 64);
      push_req(KIND_QUERY, 6, 20, 100);    // never-hit bin in range
      push_req(KIND_QUERY, 0, 0, 0);

      for (int ph = 0; ph < 6; ph++) begin
         settle();
         case (ph)
            0: write_reg(REG_FILTER, {3'($urandom), 5'd0});
            1: begin
               write_reg(REG_FILTER, {3'($urandom), 5'd5});
               for (int k = 0; k < LEVELS; k++) write_reg(REG_LEVEL6 + 3'(k), 8'd255);
            end
            2: begin
               // most negative filter matches nothing; zero thresholds make any nonzero count hot
               write_reg(REG_FILTER, {3'($urandom), 5'h10});
               for (int k = 0; k < LEVELS; k++) write_reg(REG_LEVEL6 + 3'(k), 8'd0);
               write_reg(REG_UNMAPPED, 8'($urandom));
            end
            3: begin
               write_reg(REG_FILTER, {3'($urandom), 5'd13});
               t = $urandom_range(20, 60);
               for (int k = 0; k < LEVELS; k++) begin
                  write_reg(REG_LEVEL6 + 3'(k), 8'(t));
                  t = t - $urandom_range(0, 8);
                  if (t < 0) t = 0;
               end
            end
            4: begin
               // filter names a module that does not exist; thresholds out of order
               write_reg(REG_FILTER, {3'($urandom), 5'(14 + $urandom_range(1))});
               for (int k = 0; k < LEVELS; k++) write_reg(REG_LEVEL6 + 3'(k), 8'($urandom));
            end
            default: begin
               write_reg(REG_FILTER, {3'($urandom), FILTER_ALL});
               for (int k = 0; k < LEVELS; k++)
                  write_reg(REG_LEVEL6 + 3'(k), 8'($urandom_range(10, 40)));
            end
         endcase
         wait_writes();

         send_idle_pct = (ph < 2) ? 30 : (ph < 4) ? 59 : 0;
         recv_idle_pct = (ph < 2) ? 59 : (ph < 4) ? 30 : 0;

         for (int k = 0; k < HOT_BINS; k++) begin
            hot_set[k].kind     = KIND_HIT;
            hot_set[k].mod_idx  = 4'($urandom_range(N_MOD - 1));
            hot_set[k].chip_idx = 5'($urandom_range(N_CHIP - 1));
            hot_set[k].chan_idx = 7'($urandom_range(N_CHAN - 1));
         end

         counted = 0;
         while (counted < PHASE_ITEMS) begin
            if (random_request(rq)) counted++;
            pending_requests.push_back(rq);
            // in odd phases, mid-phase the sender holds off until every report is back
            if (counted == PHASE_ITEMS / 2 && ph % 2 == 1) begin
               while (pending_requests.size() != 0 || req_tvalid) @(posedge clock);
               while (awaited_reports.size() != 0) @(posedge clock);
            end
         end
      end

      settle();
      $display("covered %0d hits (%0d dropped), %0d queries, %0d replies, %0d register writes",
               n_hits, n_dropped, n_queries, n_replies, n_writes);
      $display("thresholds at zero, full scale, random order; filter open, single, void");
      if (mismatches == 0 && awaited_reports.size() == 0) begin
         $display("hot_channel_histogram_classifier_unit regression: pass");
      end else begin
         $display("hot_channel_histogram_classifier_unit regression: fail");
      end
      $finish;
   end

endmodule

`default_nettype wire
